// ===== sv/clfp_pkg.sv =====
package clfp_pkg;

    localparam logic [7:0] CTRL_LOW  = 8'h02;
    localparam logic [7:0] CTRL_HIGH = 8'h07;

    localparam logic [15:0] RST_PAYLOAD_LIMIT   = 16'd512;
    localparam logic [7:0]  RST_MAX_CHANNEL     = 8'd1;
    localparam logic [7:0]  RST_CONTROL_CHANNEL = 8'd0;

    typedef enum logic [1:0] {
        CFG_PAYLOAD_LIMIT   = 2'd0,
        CFG_MAX_CHANNEL     = 2'd1,
        CFG_CONTROL_CHANNEL = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_EMPTY     = 2'd1,
        KIND_VIOLATION = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_CHANNEL = 2'd0,
        PH_LEN_LO  = 2'd1,
        PH_LEN_HI  = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    typedef enum logic {
        CMD_BYTE       = 1'b0,
        CMD_LINK_RESET = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [15:0] payload_limit;
        logic [7:0]  max_channel;
        logic [7:0]  control_channel;
    } t_cfg;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] channel;
        logic [7:0] payload_byte;
        logic       first_of_frame;
        logic       last_of_frame;
        logic       control_frame;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_result_req;

endpackage

// ===== sv/clfp_parse.sv =====
module clfp_parse import clfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic        i_command,
    input  logic [7:0]  i_rx_byte,
    input  t_cfg        i_cfg,
    output t_result_req o_result
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_channel, n_channel;
    logic [15:0] r_length, n_length;
    logic [15:0] r_count, n_count;
    logic        r_dropped, n_dropped;

    logic [15:0] w_len_full;
    logic [16:0] w_count_inc;
    logic        w_first;
    logic        w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_CHANNEL;
            r_channel <= 8'd0;
            r_length  <= 16'd0;
            r_count   <= 16'd0;
            r_dropped <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_channel <= n_channel;
            r_length  <= n_length;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    assign w_len_full  = {i_rx_byte, r_length[7:0]};
    assign w_count_inc = {1'b0, r_count} + 17'd1;
    assign w_first     = (r_count == 16'd0);
    assign w_last      = (w_count_inc >= {1'b0, r_length});

    always_comb begin
        n_phase   = r_phase;
        n_channel = r_channel;
        n_length  = r_length;
        n_count   = r_count;
        n_dropped = r_dropped;

        o_result.valid               = 1'b0;
        o_result.data.kind           = KIND_PAYLOAD;
        o_result.data.channel        = r_channel;
        o_result.data.payload_byte   = 8'd0;
        o_result.data.first_of_frame = 1'b0;
        o_result.data.last_of_frame  = 1'b0;
        o_result.data.control_frame  = 1'b0;

        if (t_cmd'(i_command) == CMD_LINK_RESET) begin
            n_phase   = PH_CHANNEL;
            n_channel = 8'd0;
            n_length  = 16'd0;
            n_count   = 16'd0;
            n_dropped = 1'b0;
        end else if (!r_dropped) begin
            case (r_phase)
                PH_CHANNEL: begin
                    n_channel = i_rx_byte;
                    n_phase   = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_length = {8'd0, i_rx_byte};
                    n_phase  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_count = 16'd0;
                    if (r_channel > i_cfg.max_channel
                        || w_len_full > i_cfg.payload_limit) begin
                        o_result.valid     = 1'b1;
                        o_result.data.kind = KIND_VIOLATION;
                        n_phase            = PH_CHANNEL;
                        n_length           = 16'd0;
                        n_dropped          = 1'b1;
                    end else if (w_len_full == 16'd0) begin
                        o_result.valid              = 1'b1;
                        o_result.data.kind          = KIND_EMPTY;
                        o_result.data.last_of_frame = 1'b1;
                        n_phase                     = PH_CHANNEL;
                        n_length                    = 16'd0;
                    end else begin
                        n_length = w_len_full;
                        n_phase  = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    o_result.valid               = 1'b1;
                    o_result.data.kind           = KIND_PAYLOAD;
                    o_result.data.payload_byte   = i_rx_byte;
                    o_result.data.first_of_frame = w_first;
                    o_result.data.last_of_frame  = w_last;
                    o_result.data.control_frame  = w_first
                        && (r_channel == i_cfg.control_channel)
                        && (i_rx_byte >= CTRL_LOW) && (i_rx_byte <= CTRL_HIGH);
                    if (w_last) begin
                        n_phase  = PH_CHANNEL;
                        n_length = 16'd0;
                        n_count  = 16'd0;
                    end else begin
                        n_count = w_count_inc[15:0];
                    end
                end
                default: begin
                    n_phase = PH_CHANNEL;
                end
            endcase
        end
    end

endmodule

// ===== sv/clfp_out_reg.sv =====
module clfp_out_reg import clfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result_req i_result,
    input  logic        i_stall,
    output logic        o_ready,
    output logic        o_valid,
    output t_result     o_data
);

    logic    r_valid, n_valid;
    t_result r_data;

    assign o_ready = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load && i_result.valid) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.valid) begin
            r_data <= i_result.data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== sv/channel_length_frame_parser.sv =====
// A request accepted into the input register is parsed when it fires, and its result is
// loaded into the result register, which drives the outputs, once that register can take it.
// Throughput: one request per cycle; the input register and the result register
// each advance in the same cycle as long as the result side is not stalled.
// Reset: synchronous, active low; clears the frame state, the pipeline valids
// and restores the configuration registers to their defaults.
module channel_length_frame_parser import clfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_channel,
    output logic [7:0]  o_payload_byte,
    output logic        o_first_of_frame,
    output logic        o_last_of_frame,
    output logic        o_control_frame
);

    t_cfg        r_cfg;
    logic        r_s1_valid, n_s1_valid;
    logic        r_s1_command;
    logic [7:0]  r_s1_byte;
    logic        w_out_ready;
    logic        w_fire;
    logic        w_accept;
    t_result_req w_result;
    t_result     w_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.payload_limit   <= RST_PAYLOAD_LIMIT;
            r_cfg.max_channel     <= RST_MAX_CHANNEL;
            r_cfg.control_channel <= RST_CONTROL_CHANNEL;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PAYLOAD_LIMIT:   r_cfg.payload_limit   <= i_cfg_data;
                CFG_MAX_CHANNEL:     r_cfg.max_channel     <= i_cfg_data[7:0];
                CFG_CONTROL_CHANNEL: r_cfg.control_channel <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign w_fire     = r_s1_valid && w_out_ready;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = r_s1_valid && !w_out_ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_accept) begin
            n_s1_valid = 1'b1;
        end else if (w_fire) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_command <= i_command;
            r_s1_byte    <= i_rx_byte;
        end
    end

    clfp_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_command (r_s1_command),
        .i_rx_byte (r_s1_byte),
        .i_cfg     (r_cfg),
        .o_result  (w_result)
    );

    clfp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire),
        .i_result (w_result),
        .i_stall  (i_out_stall),
        .o_ready  (w_out_ready),
        .o_valid  (o_out_valid),
        .o_data   (w_out_data)
    );

    assign o_kind           = w_out_data.kind;
    assign o_channel        = w_out_data.channel;
    assign o_payload_byte   = w_out_data.payload_byte;
    assign o_first_of_frame = w_out_data.first_of_frame;
    assign o_last_of_frame  = w_out_data.last_of_frame;
    assign o_control_frame  = w_out_data.control_frame;

    a_violation_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_VIOLATION) |->
        (!o_first_of_frame && !o_last_of_frame && !o_control_frame
         && o_payload_byte == 8'd0))
        else $error("violation result carries frame marks");

    a_empty_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_EMPTY) |->
        (o_last_of_frame && !o_first_of_frame && o_payload_byte == 8'd0))
        else $error("empty frame result has wrong marks");

    a_control_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_control_frame) |->
        (o_first_of_frame && o_kind == KIND_PAYLOAD))
        else $error("control mark off the first payload byte");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_out_ready) |=>
        (r_s1_valid && $stable(r_s1_byte) && $stable(r_s1_command)))
        else $error("held input request changed");

endmodule
